// ----- design/wcms_pkg.sv -----
// Shared constants, types and helpers for the windowed contact match scorer.
package wcms_pkg;

  localparam int MAX_CONTACTS = 1024;
  localparam int MAX_GROUPS   = 64;
  localparam int NUM_SLOTS    = 32;
  localparam int NUM_DIMS     = 7;
  localparam int IN_DIMS      = 7;

  localparam int SLOT_W   = 5;
  localparam int FUNC_W   = 2;
  localparam int PROT_W   = 6;
  localparam int CADDR_W  = $clog2(MAX_CONTACTS);
  localparam int CCNT_W   = $clog2(MAX_CONTACTS + 1);
  localparam int GADDR_W  = $clog2(MAX_GROUPS);
  localparam int GCNT_W   = $clog2(MAX_GROUPS + 1);
  localparam int TCNT_W   = 16;
  localparam int CH_W     = 11;
  localparam int SCORE_W  = 17;
  localparam int PROD_W   = TCNT_W + CCNT_W;
  localparam int FRAC_BITS = 32;
  localparam int QUO_W    = FRAC_BITS + 1;
  localparam int RT_W     = QUO_W + 1;
  localparam int DCNT_W   = $clog2(FRAC_BITS);

  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam logic REG_CUTOFF = 1'b0;

  localparam logic [SLOT_W-1:0] SLOT_MAX  = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [TCNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_MATCH  = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MATCH, S_TINC, S_CH, S_SC_RD, S_SC_MUL, S_SC_GO, S_SC_WAIT,
    S_SRT, S_SRD, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    SC_IDLE, SC_DIV, SC_SQRT, SC_DONE
  } sc_state_t;

  typedef logic [NUM_DIMS-1:0][SLOT_W-1:0] slots_t;

  typedef struct packed {
    slots_t               slots;
    logic [GADDR_W-1:0]   grp;
  } contact_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TCNT_W-1:0]  th;
    logic [CH_W-1:0]    ch;
  } grp_rec_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sc_stat_t;

  function automatic logic [SLOT_W-1:0] clamp_slot(input logic [SLOT_W-1:0] s);
    return (s > SLOT_MAX) ? SLOT_MAX : s;
  endfunction

endpackage

// ----- design/wcms_cmd_if.sv -----
// Command channel carrying one input beat.
interface wcms_cmd_if;
  import wcms_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic              new_protein;
  logic [SLOT_W-1:0] slot_0;
  logic [SLOT_W-1:0] slot_1;
  logic [SLOT_W-1:0] slot_2;
  logic [SLOT_W-1:0] slot_3;
  logic [SLOT_W-1:0] slot_4;
  logic [SLOT_W-1:0] slot_5;
  logic [SLOT_W-1:0] slot_6;

  modport source (output valid, func, new_protein, slot_0, slot_1, slot_2, slot_3,
                  slot_4, slot_5, slot_6, input ready);
  modport sink (input valid, func, new_protein, slot_0, slot_1, slot_2, slot_3,
                slot_4, slot_5, slot_6, output ready);
endinterface

// ----- design/wcms_res_if.sv -----
// Result channel carrying one report beat.
interface wcms_res_if;
  import wcms_pkg::*;
  logic               valid;
  logic               ready;
  logic [PROT_W-1:0]  protein;
  logic [SCORE_W-1:0] score;
  logic [TCNT_W-1:0]  group_target_hits;
  logic [CH_W-1:0]    group_contact_hits;
  logic               overflow;
  logic               last;

  modport source (output valid, protein, score, group_target_hits, group_contact_hits,
                  overflow, last, input ready);
  modport sink (input valid, protein, score, group_target_hits, group_contact_hits,
                overflow, last, output ready);
endinterface

// ----- design/wcms_dim_lane.sv -----
// One dimension lane: checks that two slot indices lie within the cutoff.
module wcms_dim_lane (
  input  logic [wcms_pkg::SLOT_W-1:0] stored,
  input  logic [wcms_pkg::SLOT_W-1:0] target,
  input  logic [wcms_pkg::SLOT_W-1:0] cutoff,
  output logic                        ok
);
  import wcms_pkg::*;

  logic [SLOT_W-1:0] diff;

  always_comb begin
    diff = (stored > target) ? (stored - target) : (target - stored);
    ok   = (diff <= cutoff);
  end
endmodule

// ----- design/wcms_score_unit.sv -----
// Iterative unit computing floor(65536 * sqrt(num / den)), with the ratio capped at one, by long division and root.
module wcms_score_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wcms_pkg::PROD_W-1:0]  num,
  input  logic [wcms_pkg::PROD_W-1:0]  den,
  output wcms_pkg::sc_stat_t           stat,
  output logic [wcms_pkg::SCORE_W-1:0] score
);
  import wcms_pkg::*;

  sc_state_t          state, state_next;
  logic [PROD_W-1:0]  r, r_next;
  logic [PROD_W:0]    r2;
  logic               div_ge;
  logic [QUO_W-1:0]   q, q_next;
  logic [DCNT_W-1:0]  cnt;
  logic [QUO_W-1:0]   x, x_next;
  logic [RT_W-1:0]    res, res_next, bitv, trial;
  logic               sq_ge;

  always_comb begin
    r2     = {r, 1'b0};
    div_ge = (r2 >= {1'b0, den});
    r_next = div_ge ? PROD_W'(r2 - {1'b0, den}) : r2[PROD_W-1:0];
    q_next = {q[QUO_W-2:0], div_ge};
    trial  = res + bitv;
    sq_ge  = ({1'b0, x} >= trial);
    x_next = sq_ge ? QUO_W'({1'b0, x} - trial) : x;
    res_next = sq_ge ? ((res >> 1) + bitv) : (res >> 1);
  end

  always_comb begin
    state_next = state;
    case (state)
      SC_IDLE: begin
        if (start) begin
          state_next = (num == '0 || den == '0) ? SC_DONE : SC_DIV;
        end
      end
      SC_DIV: begin
        if (cnt == DCNT_W'(FRAC_BITS - 1)) begin
          state_next = SC_SQRT;
        end
      end
      SC_SQRT: begin
        if (bitv[0]) begin
          state_next = SC_DONE;
        end
      end
      SC_DONE:  state_next = SC_IDLE;
      default:  state_next = SC_IDLE;
    endcase
    stat.busy = (state != SC_IDLE);
    stat.done = (state == SC_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SC_IDLE: begin
        cnt <= '0;
        if (start) begin
          score <= '0;
          if (num >= den) begin
            q <= QUO_W'(1);
            r <= '0;
          end else begin
            q <= '0;
            r <= num;
          end
        end
      end
      SC_DIV: begin
        r   <= r_next;
        q   <= q_next;
        cnt <= cnt + DCNT_W'(1);
        if (cnt == DCNT_W'(FRAC_BITS - 1)) begin
          x    <= q_next;
          res  <= '0;
          bitv <= RT_W'(1) << (QUO_W - 1);
        end
      end
      SC_SQRT: begin
        x    <= x_next;
        res  <= res_next;
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          score <= res_next[SCORE_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end
endmodule

// ----- design/windowed_contact_match_scorer.sv -----
// Top level: contact store, lane-parallel matcher, scoring and sorted report.
// Load stores one contact; match reads one contact per cycle from the contact memory,
// all 7 dimension lanes at once, then raises the target counts of the hit groups.
// Finish counts contact hits and scores each group in turn, then selects and reports
// one group per result beat in descending score order; an empty database reports nothing.
// One item is in work at a time. Reset is synchronous; the stores need no clearing pass.
module windowed_contact_match_scorer (
  input  logic                        clk,
  input  logic                        rst,
  wcms_cmd_if.sink                    cmd,
  wcms_res_if.source                  res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wcms_pkg::APB_AW-1:0] paddr,
  input  logic [wcms_pkg::APB_DW-1:0] pwdata,
  output logic [wcms_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import wcms_pkg::*;

  state_t             state, state_next;
  logic [SLOT_W-1:0]  cutoff;
  logic [CCNT_W-1:0]  contact_total;
  logic [GCNT_W-1:0]  group_total;
  logic [TCNT_W-1:0]  target_total;
  logic               overflow_flag;
  logic               drop_group;
  logic [CH_W-1:0]    cur_size;
  slots_t             tgt;
  logic [MAX_GROUPS-1:0] hit;
  logic [MAX_GROUPS-1:0] emitted;
  logic [CCNT_W-1:0]  idx;
  logic [GCNT_W-1:0]  gi;
  logic               rd_vld;
  logic [CADDR_W-1:0] rd_cidx;
  logic [GADDR_W-1:0] rd_gidx;
  logic [CH_W-1:0]    acc;
  logic [GADDR_W-1:0] acc_g;
  logic [PROD_W-1:0]  num, den;
  logic               have_best;
  logic [SCORE_W-1:0] best_score;
  logic [GADDR_W-1:0] best_idx;
  logic [GCNT_W-1:0]  rank;

  logic               cmd_acc;
  func_t              func;
  logic [IN_DIMS-1:0][SLOT_W-1:0] raw;
  slots_t             in_slots;
  logic               c_issue, g_issue, c_drain, g_drain;
  logic               start_grp, full_c, full_g, store;
  logic [GADDR_W-1:0] g_sel;
  logic [CH_W-1:0]    size_new;
  logic [NUM_DIMS-1:0] lane_ok;
  logic               match_ok;
  logic               last_grp, last_beat;
  logic               sc_start;
  sc_stat_t           sc_stat;
  logic [SCORE_W-1:0] sc_score;

  contact_t           cmem [MAX_CONTACTS];
  contact_t           c_rd, c_wd;
  logic               c_we;
  logic               mmem [MAX_CONTACTS];
  logic               m_rd, m_we, m_wd;
  logic [CADDR_W-1:0] m_wa;
  logic [TCNT_W-1:0]  gtc_mem [MAX_GROUPS];
  logic [TCNT_W-1:0]  gtc_rd, gtc_wd;
  logic               gtc_we;
  logic [GADDR_W-1:0] gtc_wa;
  logic [CH_W-1:0]    chm [MAX_GROUPS];
  logic [CH_W-1:0]    ch_rd, ch_wd;
  logic               ch_we;
  logic [GADDR_W-1:0] ch_wa;
  logic [CH_W-1:0]    szm [MAX_GROUPS];
  logic [CH_W-1:0]    sz_rd;
  grp_rec_t           rec_mem [MAX_GROUPS];
  grp_rec_t           rec_rd, rec_wd;
  logic               rec_we;
  logic [GADDR_W-1:0] rec_ra, g_ra;

  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_CUTOFF) ? APB_DW'(cutoff) : '0;
  assign cmd_acc = cmd.valid && cmd.ready;
  assign func    = func_t'(cmd.func);
  assign raw     = {cmd.slot_6, cmd.slot_5, cmd.slot_4, cmd.slot_3, cmd.slot_2,
                    cmd.slot_1, cmd.slot_0};

  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      in_slots[d] = clamp_slot(raw[d]);
    end
  end

  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_lane
    wcms_dim_lane u_lane (
      .stored (c_rd.slots[d]),
      .target (tgt[d]),
      .cutoff (cutoff),
      .ok     (lane_ok[d])
    );
  end
  assign match_ok = &lane_ok;

  wcms_score_unit u_score (
    .clk   (clk),
    .rst   (rst),
    .start (sc_start),
    .num   (num),
    .den   (den),
    .stat  (sc_stat),
    .score (sc_score)
  );

  always_comb begin
    c_issue   = (idx < contact_total);
    g_issue   = (gi < group_total);
    c_drain   = !c_issue && !rd_vld;
    g_drain   = !g_issue && !rd_vld;
    start_grp = cmd.new_protein || (group_total == '0);
    full_c    = (contact_total >= CCNT_W'(MAX_CONTACTS));
    full_g    = (group_total >= GCNT_W'(MAX_GROUPS));
    store     = !full_c && (start_grp ? !full_g : !drop_group);
    g_sel     = start_grp ? group_total[GADDR_W-1:0]
                          : GADDR_W'(group_total - GCNT_W'(1));
    size_new  = start_grp ? CH_W'(1) : (cur_size + CH_W'(1));
    last_grp  = ((gi + GCNT_W'(1)) == group_total);
    last_beat = (rank == (group_total - GCNT_W'(1)));
    sc_start  = (state == S_SC_GO);
    g_ra      = gi[GADDR_W-1:0];
    rec_ra    = (state == S_SRT) ? gi[GADDR_W-1:0] : best_idx;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          case (func)
            FUNC_MATCH:  state_next = S_MATCH;
            FUNC_FINISH: state_next = (contact_total == '0) ? S_IDLE : S_CH;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_MATCH:   if (c_drain) state_next = S_TINC;
      S_TINC:    if (g_drain) state_next = S_IDLE;
      S_CH:      if (c_drain) state_next = S_SC_RD;
      S_SC_RD:   state_next = S_SC_MUL;
      S_SC_MUL:  state_next = S_SC_GO;
      S_SC_GO:   state_next = S_SC_WAIT;
      S_SC_WAIT: if (sc_stat.done) state_next = last_grp ? S_SRT : S_SC_RD;
      S_SRT:     if (g_drain) state_next = S_SRD;
      S_SRD:     state_next = S_OUT;
      S_OUT:     if (res.ready) state_next = last_beat ? S_IDLE : S_SRT;
      default:   state_next = S_IDLE;
    endcase
    cmd.ready = (state == S_IDLE);
    res.valid = (state == S_OUT);
    res.protein            = PROT_W'(best_idx);
    res.score              = rec_rd.score;
    res.group_target_hits  = rec_rd.th;
    res.group_contact_hits = rec_rd.ch;
    res.overflow           = overflow_flag;
    res.last               = last_beat;
  end

  always_comb begin
    c_we = (state == S_IDLE) && cmd_acc && (func == FUNC_LOAD) && store;
    c_wd.slots = in_slots;
    c_wd.grp   = g_sel;
    m_we = 1'b0;
    m_wa = rd_cidx;
    m_wd = 1'b0;
    gtc_we = 1'b0;
    gtc_wa = g_ra;
    gtc_wd = '0;
    ch_we = 1'b0;
    ch_wa = acc_g;
    ch_wd = acc;
    rec_we = (state == S_SC_WAIT) && sc_stat.done;
    rec_wd.score = sc_score;
    rec_wd.th    = gtc_rd;
    rec_wd.ch    = ch_rd;
    case (state)
      S_IDLE: begin
        if (c_we) begin
          m_we = 1'b1;
          m_wa = contact_total[CADDR_W-1:0];
          if (start_grp) begin
            gtc_we = 1'b1;
            gtc_wa = g_sel;
          end
        end
      end
      S_MATCH: begin
        m_we = rd_vld && match_ok;
        m_wd = 1'b1;
      end
      S_TINC: begin
        gtc_we = rd_vld && hit[rd_gidx] && (gtc_rd != COUNT_MAX);
        gtc_wa = rd_gidx;
        gtc_wd = gtc_rd + TCNT_W'(1);
      end
      S_CH: begin
        m_we  = rd_vld;
        ch_we = (rd_vld && (c_rd.grp != acc_g)) || c_drain;
      end
      S_SC_WAIT: begin
        gtc_we = sc_stat.done;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[contact_total[CADDR_W-1:0]] <= c_wd;
    end
    c_rd <= cmem[idx[CADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      mmem[m_wa] <= m_wd;
    end
    m_rd <= mmem[idx[CADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (gtc_we) begin
      gtc_mem[gtc_wa] <= gtc_wd;
    end
    gtc_rd <= gtc_mem[g_ra];
  end

  always_ff @(posedge clk) begin
    if (ch_we) begin
      chm[ch_wa] <= ch_wd;
    end
    ch_rd <= chm[g_ra];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      szm[g_sel] <= size_new;
    end
    sz_rd <= szm[g_ra];
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[g_ra] <= rec_wd;
    end
    rec_rd <= rec_mem[rec_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff        <= '0;
      contact_total <= '0;
      group_total   <= '0;
      target_total  <= '0;
      overflow_flag <= 1'b0;
      drop_group    <= 1'b0;
      rd_vld        <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == REG_CUTOFF)) begin
        cutoff <= pwdata[SLOT_W-1:0];
      end
      rd_vld <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            case (func)
              FUNC_LOAD: begin
                if (full_c) begin
                  overflow_flag <= 1'b1;
                end else if (start_grp && full_g) begin
                  overflow_flag <= 1'b1;
                  drop_group    <= 1'b1;
                end else if (start_grp) begin
                  drop_group <= 1'b0;
                end else if (drop_group) begin
                  overflow_flag <= 1'b1;
                end
                if (store) begin
                  contact_total <= contact_total + CCNT_W'(1);
                  cur_size      <= size_new;
                  if (start_grp) begin
                    group_total <= group_total + GCNT_W'(1);
                  end
                end
              end
              FUNC_MATCH: begin
                tgt <= in_slots;
                hit <= '0;
                idx <= '0;
              end
              FUNC_FINISH: begin
                if (contact_total == '0) begin
                  target_total <= '0;
                end else begin
                  idx   <= '0;
                  acc   <= '0;
                  acc_g <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MATCH: begin
          rd_vld  <= c_issue;
          rd_cidx <= idx[CADDR_W-1:0];
          if (c_issue) begin
            idx <= idx + CCNT_W'(1);
          end
          if (rd_vld && match_ok) begin
            hit[c_rd.grp] <= 1'b1;
          end
          if (c_drain) begin
            gi <= '0;
          end
        end
        S_TINC: begin
          rd_vld  <= g_issue;
          rd_gidx <= gi[GADDR_W-1:0];
          if (g_issue) begin
            gi <= gi + GCNT_W'(1);
          end
          if (g_drain && (target_total != COUNT_MAX)) begin
            target_total <= target_total + TCNT_W'(1);
          end
        end
        S_CH: begin
          rd_vld  <= c_issue;
          rd_cidx <= idx[CADDR_W-1:0];
          if (c_issue) begin
            idx <= idx + CCNT_W'(1);
          end
          if (rd_vld) begin
            if (c_rd.grp != acc_g) begin
              acc   <= CH_W'(m_rd);
              acc_g <= c_rd.grp;
            end else begin
              acc <= acc + CH_W'(m_rd);
            end
          end
          if (c_drain) begin
            gi <= '0;
          end
        end
        S_SC_MUL: begin
          num <= PROD_W'(gtc_rd) * PROD_W'(ch_rd);
          den <= PROD_W'(target_total) * PROD_W'(sz_rd);
        end
        S_SC_WAIT: begin
          if (sc_stat.done) begin
            if (last_grp) begin
              target_total <= '0;
              gi           <= '0;
              emitted      <= '0;
              have_best    <= 1'b0;
              rank         <= '0;
            end else begin
              gi <= gi + GCNT_W'(1);
            end
          end
        end
        S_SRT: begin
          rd_vld  <= g_issue;
          rd_gidx <= gi[GADDR_W-1:0];
          if (g_issue) begin
            gi <= gi + GCNT_W'(1);
          end
          if (rd_vld && !emitted[rd_gidx] && (!have_best || rec_rd.score > best_score)) begin
            have_best  <= 1'b1;
            best_score <= rec_rd.score;
            best_idx   <= rd_gidx;
          end
        end
        S_OUT: begin
          if (res.ready) begin
            emitted[best_idx] <= 1'b1;
            rank              <= rank + GCNT_W'(1);
            gi                <= '0;
            have_best         <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ready && res.valid))
    else $error("Command and result beats overlap.");
  a_contact_bound: assert property (@(posedge clk) disable iff (rst)
    contact_total <= CCNT_W'(MAX_CONTACTS))
    else $error("Contact count exceeds the store depth.");
  a_groups_present: assert property (@(posedge clk) disable iff (rst)
    (group_total == '0) |-> (contact_total == '0))
    else $error("Contacts stored without a protein group.");
  a_fresh_pick: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> !emitted[best_idx])
    else $error("A protein is reported twice.");
  a_unit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !sc_stat.busy)
    else $error("Score unit busy while the block is idle.");
`endif
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the windowed contact match scorer: directed table, random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wcms_pkg::*;

  typedef struct {
    func_t  func;
    logic   np;
    slots_t s;
  } cmd_item_t;

  typedef struct {
    logic [PROT_W-1:0]  protein;
    logic [SCORE_W-1:0] score;
    logic [TCNT_W-1:0]  th;
    logic [CH_W-1:0]    ch;
    logic               ovf;
    logic               last;
  } report_t;

  typedef struct {
    cmd_item_t it;
    int        n_typed;
    report_t   typed;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  wcms_cmd_if cmd ();
  wcms_res_if res ();

  windowed_contact_match_scorer u_top (
    .clk(clk), .rst(rst), .cmd(cmd), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Model state of the scorer.
  logic [SLOT_W-1:0] db_slots [MAX_CONTACTS][NUM_DIMS];
  int                db_group [MAX_CONTACTS];
  bit                db_hit   [MAX_CONTACTS];
  int                grp_size [MAX_GROUPS];
  int                grp_targets [MAX_GROUPS];
  int                db_count, grp_count, target_count;
  bit                ovf_sticky, dropping;
  int                cutoff_val;

  report_t  expected_reports [$];
  dir_row_t dir_rows [$];
  int       mismatches, reports_seen, items_sent, matches_sent, phases_run;
  int       burst_left;
  bit       hold_done;

  function automatic logic [SCORE_W-1:0] root_q16(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[SCORE_W-1:0];
  endfunction

  function automatic logic [SCORE_W-1:0] group_score(longint unsigned num,
                                                     longint unsigned den);
    if (num == 0 || den == 0) return '0;
    return root_q16((num << 32) / den);
  endfunction

  function automatic void score_item(cmd_item_t it, ref report_t outq [$]);
    bit hit [MAX_GROUPS];
    int ch [MAX_GROUPS];
    logic [SCORE_W-1:0] sc [MAX_GROUPS];
    bit taken [MAX_GROUPS];
    bit ok;
    int g, best, diff;
    report_t r;
    case (it.func)
      FUNC_LOAD: begin
        if (db_count >= MAX_CONTACTS) begin
          ovf_sticky = 1;
        end else if (it.np || grp_count == 0) begin
          if (grp_count >= MAX_GROUPS) begin
            ovf_sticky = 1;
            dropping = 1;
          end else begin
            grp_size[grp_count] = 0;
            grp_targets[grp_count] = 0;
            grp_count++;
            dropping = 0;
            g = grp_count - 1;
          end
        end else if (dropping) begin
          ovf_sticky = 1;
        end else begin
          g = grp_count - 1;
        end
        if (db_count < MAX_CONTACTS && !dropping) begin
          for (int d = 0; d < NUM_DIMS; d++) db_slots[db_count][d] = it.s[d];
          db_group[db_count] = g;
          db_hit[db_count] = 0;
          grp_size[g]++;
          db_count++;
        end
      end
      FUNC_MATCH: begin
        for (int i = 0; i < db_count; i++) begin
          ok = 1;
          for (int d = 0; d < NUM_DIMS; d++) begin
            diff = int'(db_slots[i][d]) - int'(it.s[d]);
            if (diff < 0) diff = -diff;
            if (diff > cutoff_val) ok = 0;
          end
          if (ok) begin
            db_hit[i] = 1;
            hit[db_group[i]] = 1;
          end
        end
        for (int k = 0; k < grp_count; k++)
          if (hit[k] && grp_targets[k] < 65535) grp_targets[k]++;
        if (target_count < 65535) target_count++;
      end
      FUNC_FINISH: begin
        for (int i = 0; i < db_count; i++) if (db_hit[i]) ch[db_group[i]]++;
        for (int k = 0; k < grp_count; k++)
          sc[k] = group_score(longint'(grp_targets[k]) * ch[k],
                              longint'(target_count) * grp_size[k]);
        for (int n = 0; n < grp_count; n++) begin
          best = -1;
          for (int k = 0; k < grp_count; k++)
            if (!taken[k] && (best < 0 || sc[k] > sc[best])) best = k;
          taken[best] = 1;
          r.protein = best[PROT_W-1:0];
          r.score = sc[best];
          r.th = grp_targets[best][TCNT_W-1:0];
          r.ch = ch[best][CH_W-1:0];
          r.ovf = ovf_sticky;
          r.last = (n == grp_count - 1);
          outq = {outq, r};
        end
        for (int k = 0; k < MAX_GROUPS; k++) grp_targets[k] = 0;
        for (int i = 0; i < MAX_CONTACTS; i++) db_hit[i] = 0;
        target_count = 0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(cmd_item_t it, int n_typed = -1, report_t typed = '{default: '0});
    report_t got [$];
    if (burst_left == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    cmd.valid <= 1'b1;
    cmd.func <= it.func;
    cmd.new_protein <= it.np;
    cmd.slot_0 <= it.s[0];
    cmd.slot_1 <= it.s[1];
    cmd.slot_2 <= it.s[2];
    cmd.slot_3 <= it.s[3];
    cmd.slot_4 <= it.s[4];
    cmd.slot_5 <= it.s[5];
    cmd.slot_6 <= it.s[6];
    do @(posedge clk); while (!cmd.ready);
    score_item(it, got);
    if (n_typed < 0) expected_reports = {expected_reports, got};
    else if (n_typed == 1) expected_reports = {expected_reports, typed};
    items_sent++;
    if (it.func == FUNC_MATCH) matches_sent++;
  endtask

  task automatic settle();
    cmd.valid <= 1'b0;
    burst_left = 0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic write_cutoff(int v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(4 * REG_CUTOFF);
    pwdata <= APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    cutoff_val = v;
  endtask

  function automatic cmd_item_t mk(func_t f, logic np, slots_t s);
    cmd_item_t it;
    it.func = f;
    it.np = np;
    it.s = s;
    return it;
  endfunction

  function automatic slots_t rand_slots();
    slots_t s;
    for (int d = 0; d < NUM_DIMS; d++) s[d] = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    return s;
  endfunction

  function automatic slots_t near_slots();
    slots_t s;
    int idx, v;
    if (db_count == 0 || $urandom_range(0, 9) < 3) return rand_slots();
    idx = $urandom_range(0, db_count - 1);
    for (int d = 0; d < NUM_DIMS; d++) begin
      v = int'(db_slots[idx][d]) + $urandom_range(0, 2 * cutoff_val + 2) - cutoff_val - 1;
      if ($urandom_range(0, 3) != 0)
        v = int'(db_slots[idx][d]) + $urandom_range(0, 2 * cutoff_val) - cutoff_val;
      if (v < 0) v = 0;
      if (v > NUM_SLOTS - 1) v = NUM_SLOTS - 1;
      s[d] = SLOT_W'(v);
    end
    return s;
  endfunction

  function automatic void add_row(func_t f, logic np, slots_t s, int n = -1,
                                  report_t r = '{default: '0});
    dir_row_t row;
    row.it = mk(f, np, s);
    row.n_typed = n;
    row.typed = r;
    dir_rows = {dir_rows, row};
  endfunction

  task automatic random_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 25) send_item(mk(FUNC_LOAD, $urandom_range(0, 9) < 3, rand_slots()));
      else if (k < 85) send_item(mk(FUNC_MATCH, $urandom_range(0, 1), near_slots()));
      else if (k < 93) send_item(mk(FUNC_FINISH, $urandom_range(0, 1), rand_slots()));
      else send_item(mk(FUNC_NONE, $urandom_range(0, 1), rand_slots()));
    end
    send_item(mk(FUNC_FINISH, 1'b0, rand_slots()));
    phases_run++;
  endtask

  task automatic check_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, actual protein %0d",
                 $time, res.protein);
      end else begin
        report_t e;
        e = expected_reports.pop_front();
        check_field("protein", e.protein, res.protein);
        check_field("score", e.score, res.score);
        check_field("group_target_hits", e.th, res.group_target_hits);
        check_field("group_contact_hits", e.ch, res.group_contact_hits);
        check_field("overflow", e.ovf, res.overflow);
        check_field("last", e.last, res.last);
      end
    end
  end

  initial begin
    int mode;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && phases_run >= 2 && res.valid && cmd.valid) begin
        hold_done = 1;
        res.ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: res.ready <= 1'b1;
          1: res.ready <= $urandom_range(0, 1);
          default: res.ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    report_t r;
    slots_t zeros, ones, alt;
    int v;
    cmd.valid <= 1'b0;
    cmd.func <= FUNC_NONE;
    cmd.new_protein <= 1'b0;
    cmd.slot_0 <= '0;
    cmd.slot_1 <= '0;
    cmd.slot_2 <= '0;
    cmd.slot_3 <= '0;
    cmd.slot_4 <= '0;
    cmd.slot_5 <= '0;
    cmd.slot_6 <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    zeros = '0;
    ones = '1;
    for (int d = 0; d < NUM_DIMS; d++) alt[d] = (d % 2) ? SLOT_W'(0) : SLOT_W'(31);
    add_row(FUNC_FINISH, 1'b0, zeros, 0);
    add_row(FUNC_NONE, 1'b1, ones);
    add_row(FUNC_LOAD, 1'b0, zeros);
    r = '{protein: 0, score: 0, th: 0, ch: 0, ovf: 0, last: 1};
    add_row(FUNC_FINISH, 1'b0, zeros, 1, r);
    add_row(FUNC_MATCH, 1'b0, zeros);
    r = '{protein: 0, score: 17'd65536, th: 1, ch: 1, ovf: 0, last: 1};
    add_row(FUNC_FINISH, 1'b1, ones, 1, r);
    add_row(FUNC_LOAD, 1'b0, ones);
    add_row(FUNC_LOAD, 1'b1, alt);
    add_row(FUNC_LOAD, 1'b0, ~alt);
    add_row(FUNC_MATCH, 1'b1, ones);
    add_row(FUNC_MATCH, 1'b0, alt);
    add_row(FUNC_MATCH, 1'b0, alt);
    add_row(FUNC_MATCH, 1'b0, ~alt);
    add_row(FUNC_MATCH, 1'b0, 35'h1_2345_6789);
    add_row(FUNC_FINISH, 1'b0, zeros);
    add_row(FUNC_FINISH, 1'b0, zeros);
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].n_typed, dir_rows[i].typed);
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: v = 31;
        1: v = 0;
        2: v = 1;
        3: v = $urandom_range(2, 30);
        default: v = $urandom_range(0, 8);
      endcase
      write_cutoff(v);
      random_phase(25);
      settle();
    end

    // Fill the group store, then keep loading into the dropped group.
    write_cutoff(2);
    while (grp_count < MAX_GROUPS && db_count < MAX_CONTACTS)
      send_item(mk(FUNC_LOAD, 1'b1, rand_slots()));
    for (int i = 0; i < 8; i++) send_item(mk(FUNC_LOAD, i % 3 == 0, rand_slots()));
    send_item(mk(FUNC_MATCH, 1'b0, near_slots()));
    send_item(mk(FUNC_FINISH, 1'b0, zeros));
    settle();

    $display("Run covered %0d items (%0d targets) over %0d random phases.",
             items_sent, matches_sent, phases_run);
    $display("%0d result beats checked, %0d contacts and %0d groups loaded, %0d mismatches.",
             reports_seen, db_count, grp_count, mismatches);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/wcms_pkg.sv
design/wcms_cmd_if.sv
design/wcms_res_if.sv
design/wcms_dim_lane.sv
design/wcms_score_unit.sv
design/windowed_contact_match_scorer.sv
tb/tb_top.sv
